>>> rtl/mau_pkg.sv
package mau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_MUL    = 3'd2,
        CMD_DIV    = 3'd3,
        CMD_POW    = 3'd4,
        CMD_REDUCE = 3'd5
    } cmd_t;

    localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

    // starting values of the shared divider's bit-step counter for each kind of dividend
    localparam logic [5:0] STEPS_FULL  = 6'd63;
    localparam logic [5:0] STEPS_PROD  = 6'd61;
    localparam logic [5:0] STEPS_WORD  = 6'd31;

endpackage

>>> rtl/modular_arithmetic_unit.sv
// channel | signals                              | direction
// cfg     | cfg_valid cfg_ready cfg_data[30:0]   | in (modulus write)
// in      | in_valid in_ready cmd operand_a/b    | in
// out     | out_valid out_ready result is_equal is_less | out
//
// every division and modular reduction runs on one restoring divider, one quotient bit per cycle
// both operands are reduced on the divider first; add, subtract and reduce then finish in S_RB
// multiply adds one product reduction; power adds a square per exponent bit and a multiply per set bit
// divide adds a divider run per euclid step plus the final modular multiply
// rst_n clears control and loads modulus 1000000007; cfg_ready is always high
// a new request is taken while a finished result waits; the last step stalls on out_ready
module modular_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [30:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      cmd,
    input  logic signed [OPERAND_WIDTH-1:0] operand_a,
    input  logic signed [OPERAND_WIDTH-1:0] operand_b,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [30:0]                     result,
    output logic                            is_equal,
    output logic                            is_less
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_RA, S_RB, S_EU_CHK, S_EU_UPD, S_EU_SUB, S_EU_FIN,
        S_MULRES, S_PW_CHK, S_PW_RES, S_PW_SQ, S_PW_NX, S_DONE
    } state_t;

    state_t      state_reg, ret_reg;
    logic [30:0] mod_reg;
    logic [2:0]  cmd_reg;
    logic signed [63:0] eb_reg;
    logic        neg_b_reg;
    logic [30:0] a_reg, b_reg;
    logic        eq_reg, lt_reg;
    logic [30:0] fin_reg;
    logic [30:0] res_reg, base_reg;
    logic [62:0] exp_reg;
    logic [30:0] er_reg, er_prev_reg;
    logic signed [32:0] s_reg, s_prev_reg;
    logic signed [33:0] prod_reg;
    logic [63:0] div_q_reg;
    logic [30:0] div_rem_reg, div_d_reg;
    logic [5:0]  div_cnt_reg;
    logic        out_valid_reg;
    logic [30:0] result_reg;
    logic        is_equal_reg, is_less_reg;

    logic [30:0] m_eff;
    logic signed [63:0] ea, eb;
    logic [31:0] rem_shift;
    logic        div_ge;
    logic [30:0] rem_step;
    logic [30:0] red_fix;
    logic [32:0] s_mag;
    logic [31:0] s_sub;
    logic [30:0] s_t, inv;
    logic [30:0] one_mod;
    logic signed [65:0] q_times_s;
    logic [30:0] mul_x, mul_y;
    logic [61:0] mul_p;

    assign m_eff = (mod_reg == 31'd0) ? 31'd1 : mod_reg;
    assign ea = 64'(operand_a);
    assign eb = 64'(operand_b);
    assign one_mod = (m_eff == 31'd1) ? 31'd0 : 31'd1;

    // restoring division step
    assign rem_shift = {div_rem_reg, div_q_reg[63]};
    assign div_ge    = rem_shift >= {1'b0, div_d_reg};
    assign rem_step  = div_ge ? 31'(rem_shift - {1'b0, div_d_reg}) : rem_shift[30:0];

    // wrap a negative operand upward
    assign red_fix = (ret_reg == S_RA ? neg_b_reg : eb_reg[63]) && div_rem_reg != 31'd0
                     ? 31'(m_eff - div_rem_reg) : div_rem_reg;

    assign s_mag = s_prev_reg[32] ? 33'(-s_prev_reg) : s_prev_reg;
    assign s_sub = 32'(s_mag - {2'b0, m_eff});
    assign s_t   = (s_mag >= {2'b0, m_eff}) ? s_sub[30:0] : s_mag[30:0];
    assign inv   = (s_prev_reg[32] && s_t != 31'd0) ? 31'(m_eff - s_t) : s_t;

    assign q_times_s = $signed({1'b0, div_q_reg[31:0]}) * s_reg;

    // one shared multiplier feeds every modular product
    always_comb
    begin
        mul_x = a_reg;
        mul_y = base_reg;
        case (state_reg)
            S_RB:     mul_y = red_fix;
            S_EU_FIN: mul_y = inv;
            S_PW_CHK: mul_x = res_reg;
            S_PW_SQ:  mul_x = base_reg;
            default:  ;
        endcase
    end

    assign mul_p = mul_x * mul_y;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign is_equal  = is_equal_reg;
    assign is_less   = is_less_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            mod_reg       <= mau_pkg::MODULUS_RESET;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mod_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg     <= cmd;
                        eb_reg      <= eb;
                        neg_b_reg   <= ea[63];
                        div_q_reg   <= ea[63] ? 64'(-ea) : ea;
                        div_rem_reg <= '0;
                        div_d_reg   <= m_eff;
                        div_cnt_reg <= mau_pkg::STEPS_FULL;
                        ret_reg     <= S_RA;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_rem_reg <= rem_step;
                    div_q_reg   <= {div_q_reg[62:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd0)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_RA:
                begin
                    a_reg       <= red_fix;
                    div_q_reg   <= eb_reg[63] ? 64'(-eb_reg) : eb_reg;
                    div_rem_reg <= '0;
                    div_cnt_reg <= mau_pkg::STEPS_FULL;
                    ret_reg     <= S_RB;
                    state_reg   <= S_DIV;
                end
                S_RB:
                begin
                    b_reg     <= red_fix;
                    eq_reg    <= (a_reg == red_fix);
                    lt_reg    <= (a_reg < red_fix);
                    state_reg <= S_DONE;
                    case (cmd_reg)
                        mau_pkg::CMD_ADD:
                        begin
                            fin_reg <= 31'(({1'b0, a_reg} + {1'b0, red_fix}) >= {1'b0, m_eff}
                                       ? {1'b0, a_reg} + {1'b0, red_fix} - {1'b0, m_eff}
                                       : {1'b0, a_reg} + {1'b0, red_fix});
                        end
                        mau_pkg::CMD_SUB:
                        begin
                            fin_reg <= (a_reg >= red_fix) ? 31'(a_reg - red_fix)
                                       : 31'(a_reg + m_eff - red_fix);
                        end
                        mau_pkg::CMD_MUL:
                        begin
                            div_q_reg   <= {mul_p, 2'b00};
                            div_rem_reg <= '0;
                            div_cnt_reg <= mau_pkg::STEPS_PROD;
                            ret_reg     <= S_MULRES;
                            state_reg   <= S_DIV;
                        end
                        mau_pkg::CMD_DIV:
                        begin
                            er_prev_reg <= m_eff;
                            er_reg      <= red_fix;
                            s_prev_reg  <= '0;
                            s_reg       <= 33'sd1;
                            state_reg   <= S_EU_CHK;
                        end
                        mau_pkg::CMD_POW:
                        begin
                            res_reg  <= one_mod;
                            base_reg <= a_reg;
                            exp_reg  <= eb_reg[62:0];
                            if (eb_reg[63])
                            begin
                                fin_reg <= one_mod;
                            end
                            else
                            begin
                                state_reg <= S_PW_CHK;
                            end
                        end
                        mau_pkg::CMD_REDUCE:
                        begin
                            fin_reg <= a_reg;
                        end
                        default:
                        begin
                            fin_reg <= '0;
                        end
                    endcase
                end
                S_EU_CHK:
                begin
                    if (er_reg == 31'd0)
                    begin
                        state_reg <= S_EU_FIN;
                    end
                    else
                    begin
                        div_q_reg   <= {1'b0, er_prev_reg, 32'd0};
                        div_rem_reg <= '0;
                        div_d_reg   <= er_reg;
                        div_cnt_reg <= mau_pkg::STEPS_WORD;
                        ret_reg     <= S_EU_UPD;
                        state_reg   <= S_DIV;
                    end
                end
                S_EU_UPD:
                begin
                    prod_reg  <= q_times_s[33:0];
                    state_reg <= S_EU_SUB;
                end
                S_EU_SUB:
                begin
                    s_prev_reg  <= s_reg;
                    s_reg       <= 33'(s_prev_reg - prod_reg);
                    er_prev_reg <= er_reg;
                    er_reg      <= div_rem_reg;
                    state_reg   <= S_EU_CHK;
                end
                S_EU_FIN:
                begin
                    div_q_reg   <= {mul_p, 2'b00};
                    div_rem_reg <= '0;
                    div_d_reg   <= m_eff;
                    div_cnt_reg <= mau_pkg::STEPS_PROD;
                    ret_reg     <= S_MULRES;
                    state_reg   <= S_DIV;
                end
                S_MULRES:
                begin
                    fin_reg   <= div_rem_reg;
                    state_reg <= S_DONE;
                end
                S_PW_CHK:
                begin
                    if (exp_reg == 63'd0)
                    begin
                        fin_reg   <= res_reg;
                        state_reg <= S_DONE;
                    end
                    else if (exp_reg[0])
                    begin
                        div_q_reg   <= {mul_p, 2'b00};
                        div_rem_reg <= '0;
                        div_cnt_reg <= mau_pkg::STEPS_PROD;
                        ret_reg     <= S_PW_RES;
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_PW_SQ;
                    end
                end
                S_PW_RES:
                begin
                    res_reg   <= div_rem_reg;
                    state_reg <= S_PW_SQ;
                end
                S_PW_SQ:
                begin
                    div_q_reg   <= {mul_p, 2'b00};
                    div_rem_reg <= '0;
                    div_cnt_reg <= mau_pkg::STEPS_PROD;
                    ret_reg     <= S_PW_NX;
                    state_reg   <= S_DIV;
                end
                S_PW_NX:
                begin
                    base_reg  <= div_rem_reg;
                    exp_reg   <= exp_reg >> 1;
                    state_reg <= S_PW_CHK;
                end
                S_DONE:
                begin
                    // hold the finished request until the output register frees up
                    if (!out_valid_reg || out_ready)
                    begin
                        result_reg    <= fin_reg;
                        is_equal_reg  <= eq_reg;
                        is_less_reg   <= lt_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result_reg < m_eff)
        else $error("result not below modulus");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_d_reg != 31'd0)
        else $error("divider started with zero divisor");

    a_euclid_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EU_SUB |=> er_reg < er_prev_reg)
        else $error("euclid remainder did not shrink");

    a_add_operands: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> a_reg < m_eff && b_reg < m_eff)
        else $error("reduced operand out of range");
`endif

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [30:0] value;
        logic        eq;
        logic        lt;
    } mod_answer_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         cmd;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic               out_valid;
    logic               out_ready;
    logic [30:0]        result;
    logic               is_equal;
    logic               is_less;

    logic [30:0]  cur_modulus;
    mod_answer_t  pending_answers[$];
    int           error_count;
    int           sent_count;
    int           checked_count;
    int           idle_cycles;
    int           stall_mode;
    int           burst_left;
    int           cfg_writes;

    modular_arithmetic_unit #(.OPERAND_WIDTH(64)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready), .result(result),
        .is_equal(is_equal), .is_less(is_less)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] wrap_into(logic [63:0] v, logic [63:0] m);
        logic [63:0] r;
        begin
            if (v[63])
            begin
                r = (64'd0 - v) % m;
                return (r == 0) ? 64'd0 : m - r;
            end
            return v % m;
        end
    endfunction

    function automatic logic [63:0] euclid_inverse(logic [63:0] a, logic [63:0] m);
        logic [63:0] quot[64];
        logic [63:0] p, r, t;
        longint x, y, nx;
        int n;
        begin
            p = a;
            r = m;
            n = 0;
            x = 0;
            y = 1;
            while (p != 0 && n < 64)
            begin
                t = r % p;
                quot[n] = r / p;
                r = p;
                p = t;
                n++;
            end
            while (n > 0)
            begin
                n--;
                nx = y - longint'(quot[n]) * x;
                y = x;
                x = nx;
            end
            x = x % longint'(m);
            if (x < 0)
                x += longint'(m);
            return 64'(x);
        end
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] e,
                                              logic [63:0] m);
        logic [63:0] acc;
        begin
            acc = 64'd1 % m;
            if (e[63])
                return acc;
            while (e != 0)
            begin
                if (e[0])
                    acc = (acc * base) % m;
                base = (base * base) % m;
                e = e >> 1;
            end
            return acc;
        end
    endfunction

    function automatic mod_answer_t compute_answer(logic [2:0] c, logic [63:0] ra,
                                                   logic [63:0] rb);
        logic [63:0] m, a, b, r;
        mod_answer_t ans;
        begin
            m = (cur_modulus == 0) ? 64'd1 : 64'(cur_modulus);
            a = wrap_into(ra, m);
            b = wrap_into(rb, m);
            case (c)
                mau_pkg::CMD_ADD:    r = (a + b) % m;
                mau_pkg::CMD_SUB:    r = (a >= b) ? a - b : a + m - b;
                mau_pkg::CMD_MUL:    r = (a * b) % m;
                mau_pkg::CMD_DIV:    r = (a * euclid_inverse(b, m)) % m;
                mau_pkg::CMD_POW:    r = mod_power(a, rb, m);
                mau_pkg::CMD_REDUCE: r = a;
                default:             r = 64'd0;
            endcase
            ans.value = r[30:0];
            ans.eq = (a == b);
            ans.lt = (a < b);
            return ans;
        end
    endfunction

    // receiver stall pattern changes every so often
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
        endcase
    end

    always @(posedge clk)
    begin
        mod_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result with no request pending: %h %b %b",
                         $time, result, is_equal, is_less);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result !== want.value)
                begin
                    $display("%0t: result expected %0d actual %0d", $time, want.value, result);
                    error_count++;
                end
                if (is_equal !== want.eq)
                begin
                    $display("%0t: is_equal expected %b actual %b", $time, want.eq, is_equal);
                    error_count++;
                end
                if (is_less !== want.lt)
                begin
                    $display("%0t: is_less expected %b actual %b", $time, want.lt, is_less);
                    error_count++;
                end
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", pending_answers.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays high through a burst and drops only for a gap between bursts
    task automatic send_request(logic [2:0] c, logic [63:0] a, logic [63:0] b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        burst_left--;
        cmd <= c;
        operand_a <= a;
        operand_b <= b;
        in_valid <= 1'b1;
        pending_answers.insert(pending_answers.size(), compute_answer(c, a, b));
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_modulus(logic [30:0] m);
        drain();
        cur_modulus = m;
        cfg_data <= m;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [63:0] random_operand();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 40));
            2: return -64'($urandom_range(1, 40));
            3: return 64'(cur_modulus) * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
            4: return 64'($urandom);
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic test_extremes;
        send_request(mau_pkg::CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_request(mau_pkg::CMD_SUB, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(mau_pkg::CMD_MUL, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_request(mau_pkg::CMD_REDUCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
        send_request(mau_pkg::CMD_REDUCE, 64'd1000000007, 64'd1000000007);
        send_request(mau_pkg::CMD_SUB, 64'd3, 64'd9);
    endtask

    task automatic test_special_cases;
        // zero divisor, zero and negative exponent, spare commands
        send_request(mau_pkg::CMD_DIV, 64'd17, 64'd0);
        send_request(mau_pkg::CMD_DIV, 64'd17, 64'd1000000007);
        send_request(mau_pkg::CMD_DIV, 64'd1, 64'd2);
        send_request(mau_pkg::CMD_POW, 64'd0, 64'd0);
        send_request(mau_pkg::CMD_POW, 64'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(mau_pkg::CMD_POW, 64'd2, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(mau_pkg::CMD_POW, 64'd3, 64'd1000000006);
        send_request(CMD_SPARE6, 64'd4, 64'd9);
        send_request(CMD_SPARE7, 64'd9, 64'd4);
    endtask

    task automatic test_small_moduli;
        write_modulus(31'd0);
        send_request(mau_pkg::CMD_ADD, 64'd5, 64'd7);
        send_request(mau_pkg::CMD_POW, 64'd5, 64'd0);
        write_modulus(31'd2);
        send_request(mau_pkg::CMD_DIV, 64'd1, 64'd1);
        send_request(mau_pkg::CMD_MUL, -64'sd3, 64'd3);
        // non-coprime divisor
        write_modulus(31'd12);
        send_request(mau_pkg::CMD_DIV, 64'd5, 64'd8);
        send_request(mau_pkg::CMD_POW, 64'd7, 64'd13);
        write_modulus(31'h7FFF_FFFF);
        send_request(mau_pkg::CMD_MUL, 64'h7FFF_FFFE, 64'h7FFF_FFFE);
        send_request(mau_pkg::CMD_DIV, 64'd1, 64'h7FFF_FFFE);
    endtask

    task automatic test_random(int count);
        logic [30:0] moduli[6] = '{31'd1000000007, 31'd97, 31'h7FFF_FFFF, 31'd2,
                                   31'd65536, 31'd3};
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i % 45 == 0)
                write_modulus(($urandom_range(0, 4) == 0) ? 31'($urandom) : moduli[i / 45 % 6]);
            if (i == count / 2)
                drain();
            send_request(3'($urandom_range(0, 7)), random_operand(), random_operand());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        operand_a = '0;
        operand_b = '0;
        out_ready = 1'b0;
        stall_mode = 0;
        burst_left = 0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        idle_cycles = 0;
        cfg_writes = 0;
        cur_modulus = mau_pkg::MODULUS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_special_cases();
        test_small_moduli();
        test_random(270);
        drain();
        $display("%0d requests sent, %0d results checked, %0d modulus writes",
                 sent_count, checked_count, cfg_writes);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
